// ----- src/ipfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipfd_pkg - shared types and constants for the IR pulse frame decoder
// Phase and status codes, register map, reset values and the bit-reverse
// helper.
// ----------------------------------------------------------------------------
package ipfd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int EDGE_W        = 32;
  localparam int CFG_W         = 16;
  localparam int DATA_BITS     = 16;
  localparam int COUNT_W       = 5;
  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = 4;
  localparam int PDATA_W       = 32;

  localparam logic [CFG_W-1:0] LEADER_MIN_RST    = 16'd5250;
  localparam logic [CFG_W-1:0] LEADER_MAX_RST    = 16'd10250;
  localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 16'd1500;

  typedef enum logic [1:0] {
    REG_LEADER_MIN    = 2'd0,
    REG_LEADER_MAX    = 2'd1,
    REG_ONE_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LEADER_ERR = 2'd1,
    ST_CHECK_ERR  = 2'd2
  } status_t;

  function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[BYTE_W-1-k] = b[k];
    end
    return r;
  endfunction

endpackage

// ----- src/ipfd_if.sv -----
// ----------------------------------------------------------------------------
// ipfd_if - valid/ready channels of the IR pulse frame decoder
// Edge transactions in, decoded frame transactions out.
// ----------------------------------------------------------------------------
interface ipfd_in_if;
  logic                             valid;
  logic                             ready;
  logic [ipfd_pkg::EDGE_W-1:0]      edge_time;
  logic                             rising;
  logic                             abort;

  modport source (output valid, output edge_time, output rising, output abort,
                  input ready);
  modport sink   (input valid, input edge_time, input rising, input abort,
                  output ready);
endinterface

interface ipfd_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [ipfd_pkg::BYTE_W-1:0]      command;
  logic [ipfd_pkg::BYTE_W-1:0]      first_byte;
  logic [ipfd_pkg::BYTE_W-1:0]      second_byte;

  modport source (output valid, output status, output command, output first_byte,
                  output second_byte, input ready);
  modport sink   (input valid, input status, input command, input first_byte,
                  input second_byte, output ready);
endinterface

// ----- src/ir_pulse_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_unit - IR remote control frame decoder
// Output: the result register is loaded by the edge transaction that ends
// the frame. Throughput: one edge transaction per cycle; the result register
// decouples the channels, so input stalls only while a result waits unread.
// Reset: synchronous, active low; idle phase, registers at their defaults.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_unit #(
  parameter int TIME_BITS = ipfd_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ipfd_in_if.sink                       in_ch,
  ipfd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipfd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ipfd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ipfd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [ipfd_pkg::CFG_W-1:0]      leader_min_r;
  logic [ipfd_pkg::CFG_W-1:0]      leader_max_r;
  logic [ipfd_pkg::CFG_W-1:0]      one_threshold_r;

  ipfd_pkg::phase_t                phase_r, phase_nxt;
  logic [TIME_BITS-1:0]            prev_time_r, prev_time_nxt;
  logic [ipfd_pkg::COUNT_W-1:0]    fall_cnt_r, fall_cnt_nxt;
  logic [ipfd_pkg::DATA_BITS-1:0]  bits_r, bits_nxt;

  logic                            out_valid_r;
  ipfd_pkg::status_t               status_r, status_nxt;
  logic [ipfd_pkg::BYTE_W-1:0]     command_r, command_nxt;
  logic [ipfd_pkg::BYTE_W-1:0]     byte0_r, byte0_nxt;
  logic [ipfd_pkg::BYTE_W-1:0]     byte1_r, byte1_nxt;

  logic                            in_accept;
  logic                            res_valid;
  logic                            cfg_write;
  ipfd_pkg::reg_idx_t              cfg_idx;
  logic [TIME_BITS-1:0]            t_now;
  logic [TIME_BITS-1:0]            gap;
  logic [3:0]                      bit_idx;
  logic [ipfd_pkg::BYTE_W-1:0]     b0, b1;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = ipfd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_min_r    <= ipfd_pkg::LEADER_MIN_RST;
      leader_max_r    <= ipfd_pkg::LEADER_MAX_RST;
      one_threshold_r <= ipfd_pkg::ONE_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        ipfd_pkg::REG_LEADER_MIN:    leader_min_r    <= pwdata[ipfd_pkg::CFG_W-1:0];
        ipfd_pkg::REG_LEADER_MAX:    leader_max_r    <= pwdata[ipfd_pkg::CFG_W-1:0];
        ipfd_pkg::REG_ONE_THRESHOLD: one_threshold_r <= pwdata[ipfd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ipfd_pkg::REG_LEADER_MIN:    prdata = ipfd_pkg::PDATA_W'(leader_min_r);
      ipfd_pkg::REG_LEADER_MAX:    prdata = ipfd_pkg::PDATA_W'(leader_max_r);
      ipfd_pkg::REG_ONE_THRESHOLD: prdata = ipfd_pkg::PDATA_W'(one_threshold_r);
      default:                     prdata = '0;
    endcase
  end

  // channel handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign t_now   = in_ch.edge_time[TIME_BITS-1:0];
  assign gap     = t_now - prev_time_r;
  assign bit_idx = 4'(fall_cnt_r - ipfd_pkg::COUNT_W'(1));
  assign b0      = bits_r[ipfd_pkg::BYTE_W-1:0];
  assign b1      = bits_r[ipfd_pkg::DATA_BITS-1:ipfd_pkg::BYTE_W];

  always_comb begin
    phase_nxt     = phase_r;
    prev_time_nxt = prev_time_r;
    fall_cnt_nxt  = fall_cnt_r;
    bits_nxt      = bits_r;
    res_valid     = 1'b0;
    status_nxt    = ipfd_pkg::ST_LEADER_ERR;
    command_nxt   = '0;
    byte0_nxt     = '0;
    byte1_nxt     = '0;
    if (in_ch.abort) begin
      phase_nxt    = ipfd_pkg::PH_IDLE;
      fall_cnt_nxt = '0;
      bits_nxt     = '0;
    end else begin
      case (phase_r)
        ipfd_pkg::PH_LEADER: begin
          fall_cnt_nxt = '0;
          bits_nxt     = '0;
          if (in_ch.rising && gap > TIME_BITS'(leader_min_r)
              && gap < TIME_BITS'(leader_max_r)) begin
            phase_nxt = ipfd_pkg::PH_DATA;
          end else begin
            phase_nxt = ipfd_pkg::PH_IDLE;
            res_valid = 1'b1;
          end
        end
        ipfd_pkg::PH_DATA: begin
          if (!in_ch.rising) begin
            if (fall_cnt_r == '0) begin
              prev_time_nxt = t_now;
              fall_cnt_nxt  = ipfd_pkg::COUNT_W'(1);
            end else if (fall_cnt_r <= ipfd_pkg::COUNT_W'(ipfd_pkg::DATA_BITS)) begin
              if (gap > TIME_BITS'(one_threshold_r)) begin
                bits_nxt = bits_r | (ipfd_pkg::DATA_BITS'(1) << bit_idx);
              end
              prev_time_nxt = t_now;
              fall_cnt_nxt  = fall_cnt_r + ipfd_pkg::COUNT_W'(1);
            end else begin
              phase_nxt    = ipfd_pkg::PH_IDLE;
              fall_cnt_nxt = '0;
              bits_nxt     = '0;
              res_valid    = 1'b1;
              byte0_nxt    = b0;
              byte1_nxt    = b1;
              if (b0 == ~b1) begin
                status_nxt  = ipfd_pkg::ST_OK;
                command_nxt = ipfd_pkg::reverse8(b0);
              end else begin
                status_nxt  = ipfd_pkg::ST_CHECK_ERR;
              end
            end
          end
        end
        default: begin
          fall_cnt_nxt = '0;
          bits_nxt     = '0;
          if (in_ch.rising) begin
            phase_nxt = ipfd_pkg::PH_IDLE;
            res_valid = 1'b1;
          end else begin
            prev_time_nxt = t_now;
            phase_nxt     = ipfd_pkg::PH_LEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ipfd_pkg::PH_IDLE;
      prev_time_r <= '0;
      fall_cnt_r  <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r     <= phase_nxt;
        prev_time_r <= prev_time_nxt;
        fall_cnt_r  <= fall_cnt_nxt;
        bits_r      <= bits_nxt;
      end
      if (in_accept && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      status_r  <= status_nxt;
      command_r <= command_nxt;
      byte0_r   <= byte0_nxt;
      byte1_r   <= byte1_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.command     = command_r;
  assign out_ch.first_byte  = byte0_r;
  assign out_ch.second_byte = byte1_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fall_cnt_r <= ipfd_pkg::COUNT_W'(ipfd_pkg::DATA_BITS + 1))
    else $error("falling edge count past frame end");

  a_result_idles: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && res_valid |=> phase_r == ipfd_pkg::PH_IDLE)
    else $error("phase not idle after a result");

  a_clean_outside_data: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != ipfd_pkg::PH_DATA |-> fall_cnt_r == '0 && bits_r == '0)
    else $error("stale frame state outside data phase");

  a_command_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ipfd_pkg::ST_OK |-> command_r == '0)
    else $error("command set on a failed frame");

  a_ok_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ipfd_pkg::ST_OK |-> byte0_r == ~byte1_r)
    else $error("ok status with mismatched check byte");
`endif

endmodule
